// ===== rtl/jctc_pkg.sv =====
// jctc_pkg: shared types and character constants of the json character classifier
// used by the front, queue, back and top level
// no dependencies
package jctc_pkg;

  // lookahead window: the byte under decision plus four bytes after it
  localparam int unsigned WIN_BYTES   = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  // characters that drive the scanner
  localparam logic [7:0] CHR_LBRACE    = 8'h7B;
  localparam logic [7:0] CHR_RBRACE    = 8'h7D;
  localparam logic [7:0] CHR_LBRACKET  = 8'h5B;
  localparam logic [7:0] CHR_RBRACKET  = 8'h5D;
  localparam logic [7:0] CHR_COMMA     = 8'h2C;
  localparam logic [7:0] CHR_COLON     = 8'h3A;
  localparam logic [7:0] CHR_QUOTE     = 8'h22;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_MINUS     = 8'h2D;
  localparam logic [7:0] CHR_PLUS      = 8'h2B;
  localparam logic [7:0] CHR_DOT       = 8'h2E;
  localparam logic [7:0] CHR_LOWER_E   = 8'h65;
  localparam logic [7:0] CHR_UPPER_E   = 8'h45;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_NINE      = 8'h39;

  // literal words, first character in the top byte
  localparam logic [31:0] WORD_TRUE  = "true";
  localparam logic [31:0] WORD_NULL  = "null";
  localparam logic [39:0] WORD_FALSE = "false";

  typedef enum logic [2:0] {
    CLS_NONE    = 3'd0,
    CLS_PUNCT   = 3'd1,
    CLS_KEY     = 3'd2,
    CLS_VALUE   = 3'd3,
    CLS_NUMBER  = 3'd4,
    CLS_LITERAL = 3'd5
  } char_class_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ESCAPE = 2'd2,
    MODE_NUMBER = 2'd3
  } scan_mode_e;

  // one byte ready for classification, with its lookahead
  typedef struct packed {
    logic [WIN_BYTES-1:0][7:0] win;    // win[0] is the byte itself
    logic [2:0]                avail;  // valid bytes in win, 1 to 5
    logic                      last;   // last byte of the line
  } entry_t;

endpackage

// ===== rtl/jctc_in_if.sv =====
// jctc_in_if: input channel, one text byte per beat with its line end flag
// depends on nothing
interface jctc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

// ===== rtl/jctc_out_if.sv =====
// jctc_out_if: output channel, one classified byte per beat
// depends on nothing
interface jctc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] char_class;
  logic       run_last;

  modport source (output valid, output out_byte, output char_class, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input char_class, input run_last,
                  output ready);
endinterface

// ===== rtl/json_char_token_classifier.sv =====
// channel  | dir | beat payload                        | handshake
// in_i     | in  | text_byte[7:0], line_end            | valid / ready
// out_o    | out | out_byte[7:0], char_class[2:0], run_last | valid / ready
//
// one byte per cycle in steady state; a byte's result leaves once four later
// bytes of its line have arrived, set by the five byte lookahead window
// after a line end beat the window drains one byte per cycle while the queue
// takes them, before the next byte is taken; the scanner clears after the last one
// rst_ni is asynchronous, active low; either side may stall at any time, the
// entry queue and the output register let front and back stall on their own
//
// top level: front window, entry queue, back classifier
// depends on jctc_pkg, jctc_in_if, jctc_out_if, jctc_front, jctc_queue, jctc_back
module json_char_token_classifier #(
  parameter int unsigned QueueDepth = jctc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jctc_in_if.sink     in_i,
  jctc_out_if.source  out_o
);

  logic             f_valid, f_ready;
  jctc_pkg::entry_t f_entry;
  logic             b_valid, b_ready;
  jctc_pkg::entry_t b_entry;

  // window and entry generation
  jctc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .ent_valid_o (f_valid),
    .ent_ready_i (f_ready),
    .ent_o       (f_entry)
  );

  // decoupling queue
  jctc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_entry_i (f_entry),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_entry_o  (b_entry)
  );

  // scanner and output register
  jctc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (b_valid),
    .ent_ready_o (b_ready),
    .ent_i       (b_entry),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/jctc_front.sv =====
// jctc_front: collects input beats into the five byte lookahead window and hands
// out one window entry per cycle while the queue is ready; depends on jctc_pkg and jctc_in_if
module jctc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  jctc_in_if.sink          in_i,
  output logic             ent_valid_o,
  input  logic             ent_ready_i,
  output jctc_pkg::entry_t ent_o
);

  localparam int unsigned WinB = jctc_pkg::WIN_BYTES;

  logic [WinB-1:0][7:0] win_q, win_d, win_shift;
  logic [2:0]           fill_q, fill_d, fill_after;
  logic                 flush_q, flush_d;
  logic                 emit, accept;

  // a full window releases its head; during a flush every byte goes out
  assign ent_valid_o = flush_q ? (fill_q != 3'd0) : (fill_q == 3'(WinB));
  assign emit        = ent_valid_o && ent_ready_i;
  assign in_i.ready  = !flush_q && ((fill_q != 3'(WinB)) || emit);
  assign accept      = in_i.valid && in_i.ready;

  // entry seen by the queue
  assign ent_o.win   = win_q;
  assign ent_o.avail = fill_q;
  assign ent_o.last  = flush_q && (fill_q == 3'd1);

  // shift on emit, then append the accepted byte
  assign fill_after = fill_q - {2'b00, emit};

  always_comb begin
    for (int i = 0; i < WinB; i++) begin
      if (emit) begin
        win_shift[i] = (i < WinB - 1) ? win_q[(i + 1) % WinB] : 8'h00;
      end else begin
        win_shift[i] = win_q[i];
      end
    end
    for (int i = 0; i < WinB; i++) begin
      if (accept && (fill_after == 3'(i))) begin
        win_d[i] = in_i.text_byte;
      end else begin
        win_d[i] = win_shift[i];
      end
    end
    fill_d = fill_after + {2'b00, accept};
  end

  // flush starts with a line end beat and stops once the window is empty
  always_comb begin
    flush_d = flush_q;
    if (accept && in_i.line_end) begin
      flush_d = 1'b1;
    end else if (emit && ent_o.last) begin
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      flush_q <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== rtl/jctc_queue.sv =====
// jctc_queue: short fifo of window entries between front and back
// depends on jctc_pkg
module jctc_queue #(
  parameter int unsigned Depth = jctc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  jctc_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output jctc_pkg::entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jctc_pkg::entry_t    store_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = store_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      count_q <= count_q + CntW'(push) - CntW'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== rtl/jctc_back.sv =====
// jctc_back: scanner state machine that tags each window entry with its class
// and holds the result beat; depends on jctc_pkg and jctc_out_if
module jctc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ent_valid_i,
  output logic             ent_ready_o,
  input  jctc_pkg::entry_t ent_i,
  jctc_out_if.source       out_o
);

  jctc_pkg::scan_mode_e  mode_q, mode_d;
  logic [2:0]            lit_q, lit_d;
  logic                  sval_q, sval_d;
  logic                  expect_q, expect_d;
  jctc_pkg::char_class_e cls;

  logic                  out_valid_q;
  logic [7:0]            out_byte_q;
  jctc_pkg::char_class_e out_class_q;
  logic                  out_last_q;

  logic [7:0] c;
  logic       pop, is_digit, num_cont, is_punct, lit4, lit5, fresh;
  jctc_pkg::char_class_e str_cls, open_cls;

  assign pop         = ent_valid_i && ent_ready_o;
  assign ent_ready_o = !out_valid_q || out_o.ready;

  // character decode
  assign c        = ent_i.win[0];
  assign is_digit = (c >= jctc_pkg::CHR_ZERO) && (c <= jctc_pkg::CHR_NINE);
  assign num_cont = is_digit || (c == jctc_pkg::CHR_DOT) || (c == jctc_pkg::CHR_LOWER_E) ||
                    (c == jctc_pkg::CHR_UPPER_E) || (c == jctc_pkg::CHR_PLUS) ||
                    (c == jctc_pkg::CHR_MINUS);
  assign is_punct = (c == jctc_pkg::CHR_LBRACE) || (c == jctc_pkg::CHR_RBRACE) ||
                    (c == jctc_pkg::CHR_LBRACKET) || (c == jctc_pkg::CHR_RBRACKET) ||
                    (c == jctc_pkg::CHR_COMMA);
  assign lit4 = (ent_i.avail >= 3'd4) &&
                (({ent_i.win[0], ent_i.win[1], ent_i.win[2], ent_i.win[3]} ==
                  jctc_pkg::WORD_TRUE) ||
                 ({ent_i.win[0], ent_i.win[1], ent_i.win[2], ent_i.win[3]} ==
                  jctc_pkg::WORD_NULL));
  assign lit5 = (ent_i.avail == 3'd5) &&
                ({ent_i.win[0], ent_i.win[1], ent_i.win[2], ent_i.win[3], ent_i.win[4]} ==
                 jctc_pkg::WORD_FALSE);

  // byte outside any token, or the byte that ends a number
  assign fresh    = (mode_q == jctc_pkg::MODE_IDLE) ||
                    ((mode_q == jctc_pkg::MODE_NUMBER) && !num_cont);
  assign str_cls  = sval_q   ? jctc_pkg::CLS_VALUE : jctc_pkg::CLS_KEY;
  assign open_cls = expect_q ? jctc_pkg::CLS_VALUE : jctc_pkg::CLS_KEY;

  // class of the current byte
  always_comb begin
    cls = jctc_pkg::CLS_NONE;
    if (lit_q != 3'd0) begin
      cls = jctc_pkg::CLS_LITERAL;
    end else if ((mode_q == jctc_pkg::MODE_STRING) || (mode_q == jctc_pkg::MODE_ESCAPE)) begin
      cls = str_cls;
    end else if (!fresh) begin
      cls = jctc_pkg::CLS_NUMBER;
    end else if (is_punct || (c == jctc_pkg::CHR_COLON)) begin
      cls = jctc_pkg::CLS_PUNCT;
    end else if (c == jctc_pkg::CHR_QUOTE) begin
      cls = open_cls;
    end else if (is_digit || (c == jctc_pkg::CHR_MINUS)) begin
      cls = jctc_pkg::CLS_NUMBER;
    end else if (lit4 || lit5) begin
      cls = jctc_pkg::CLS_LITERAL;
    end
  end

  // next scanner state
  always_comb begin
    mode_d   = mode_q;
    lit_d    = lit_q;
    sval_d   = sval_q;
    expect_d = expect_q;
    if (lit_q != 3'd0) begin
      lit_d = lit_q - 3'd1;
    end else begin
      unique case (mode_q)
        jctc_pkg::MODE_ESCAPE: begin
          mode_d = jctc_pkg::MODE_STRING;
        end
        jctc_pkg::MODE_STRING: begin
          if (c == jctc_pkg::CHR_BACKSLASH) begin
            mode_d = jctc_pkg::MODE_ESCAPE;
          end else if (c == jctc_pkg::CHR_QUOTE) begin
            mode_d = jctc_pkg::MODE_IDLE;
          end
        end
        jctc_pkg::MODE_IDLE, jctc_pkg::MODE_NUMBER: begin
          if (fresh) begin
            mode_d = jctc_pkg::MODE_IDLE;
            if (is_punct) begin
              if (c == jctc_pkg::CHR_LBRACE) begin
                expect_d = 1'b0;
              end
            end else if (c == jctc_pkg::CHR_COLON) begin
              expect_d = 1'b1;
            end else if (c == jctc_pkg::CHR_QUOTE) begin
              sval_d = expect_q;
              mode_d = jctc_pkg::MODE_STRING;
            end else if (is_digit || (c == jctc_pkg::CHR_MINUS)) begin
              mode_d   = jctc_pkg::MODE_NUMBER;
              expect_d = 1'b0;
            end else if (lit4) begin
              lit_d    = 3'd3;
              expect_d = 1'b0;
            end else if (lit5) begin
              lit_d    = 3'd4;
              expect_d = 1'b0;
            end
          end
        end
        default: begin
          mode_d = jctc_pkg::MODE_IDLE;
        end
      endcase
    end
  end

  // scanner state, cleared after the last byte of a line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= jctc_pkg::MODE_IDLE;
      lit_q    <= '0;
      sval_q   <= 1'b0;
      expect_q <= 1'b0;
    end else if (pop) begin
      if (ent_i.last) begin
        mode_q   <= jctc_pkg::MODE_IDLE;
        lit_q    <= '0;
        sval_q   <= 1'b0;
        expect_q <= 1'b0;
      end else begin
        mode_q   <= mode_d;
        lit_q    <= lit_d;
        sval_q   <= sval_d;
        expect_q <= expect_d;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ent_ready_o) begin
      out_valid_q <= ent_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q  <= c;
      out_class_q <= cls;
      out_last_q  <= ent_i.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.char_class = out_class_q;
  assign out_o.run_last   = out_last_q;

endmodule
